// ===== rtl/core/psri_pkg.sv =====
`timescale 1ns / 1ps

package psri_pkg;

   // field widths
   localparam int RAW_W       = 32;
   localparam int PREC_W      = 5;
   localparam int SAMPLE_W    = 16;
   localparam int SCALED_W    = 16;
   localparam int CHAN_W      = 2;
   localparam int CCOUNT_W    = 3;
   localparam int DIM_W       = 16;
   localparam int DIVIDEND_W  = 32;
   localparam int STEP_W      = 4;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   localparam logic [PREC_W-1:0]   PREC_MIN     = PREC_W'(1);
   localparam logic [PREC_W-1:0]   PREC_MAX     = PREC_W'(SAMPLE_W);
   localparam logic [CCOUNT_W-1:0] MAX_CHANNELS = CCOUNT_W'(4);
   localparam logic [STEP_W-1:0]   STEP_LAST    = STEP_W'(SCALED_W - 1);

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_WIDE   = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_TILE_WIDTH    = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_TILE_HEIGHT   = CSR_INDEX_W'(3);

   typedef struct packed {
      logic                output_wide;
      logic [CCOUNT_W-1:0] channel_count;
      logic [DIM_W-1:0]    tile_width;
      logic [DIM_W-1:0]    tile_height;
   } cfg_type;

   typedef struct packed {
      logic [CHAN_W-1:0] channel_index;
      logic              pixel_end;
      logic              tile_end;
   } tag_type;

   typedef struct packed {
      logic                output_wide;
      logic [PREC_W-1:0]   precision;
      logic [SAMPLE_W-1:0] sample;
      tag_type             tag;
   } entry_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_RUN
   } back_state_type;

endpackage

// ===== rtl/core/psri_req_if.sv =====
`timescale 1ns / 1ps

interface psri_req_if;
   import psri_pkg::*;

   logic              valid;
   logic              ready;
   logic [RAW_W-1:0]  raw_sample;
   logic [PREC_W-1:0] sample_precision;
   logic              sample_signed;

   modport source (output valid, raw_sample, sample_precision, sample_signed, input ready);
   modport sink (input valid, raw_sample, sample_precision, sample_signed, output ready);
endinterface

// ===== rtl/core/psri_rsp_if.sv =====
`timescale 1ns / 1ps

interface psri_rsp_if;
   import psri_pkg::*;

   logic                valid;
   logic                ready;
   logic [SCALED_W-1:0] scaled_value;
   logic [CHAN_W-1:0]   channel_index;
   logic                pixel_end;
   logic                tile_end;

   modport source (output valid, scaled_value, channel_index, pixel_end, tile_end,
                   input ready);
   modport sink (input valid, scaled_value, channel_index, pixel_end, tile_end,
                 output ready);
endinterface

// ===== rtl/core/psri_csr_if.sv =====
`timescale 1ns / 1ps

interface psri_csr_if;
   import psri_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/psri_front.sv =====
`timescale 1ns / 1ps

module psri_front (
   input  logic                clock,
   input  logic                reset,
   input  psri_pkg::cfg_type   cfg,
   psri_req_if.sink            req,
   input  logic                queue_full,
   output logic                push,
   output psri_pkg::entry_type push_data
);
   import psri_pkg::*;

   logic [CHAN_W-1:0] chan_ff, chan_in;
   logic [DIM_W-1:0]  col_ff, col_in;
   logic [DIM_W-1:0]  row_ff, row_in;

   logic [CCOUNT_W-1:0] nch;
   logic [DIM_W-1:0]    width_eff;
   logic [DIM_W-1:0]    height_eff;
   logic                last_ch, last_col, last_row;
   logic [PREC_W-1:0]   prec;
   logic [SAMPLE_W:0]   src_max;
   logic [RAW_W:0]      offset;
   logic [RAW_W:0]      shifted;
   logic                below, above;
   logic [SAMPLE_W-1:0] clamped;

   always_comb begin
      // effective limits
      if (cfg.channel_count == '0) begin
         nch = CCOUNT_W'(1);
      end else if (cfg.channel_count > MAX_CHANNELS) begin
         nch = MAX_CHANNELS;
      end else begin
         nch = cfg.channel_count;
      end
      width_eff  = (cfg.tile_width == '0) ? DIM_W'(1) : cfg.tile_width;
      height_eff = (cfg.tile_height == '0) ? DIM_W'(1) : cfg.tile_height;

      last_ch  = ({1'b0, chan_ff} + CCOUNT_W'(1)) >= nch;
      last_col = ({1'b0, col_ff} + (DIM_W + 1)'(1)) >= {1'b0, width_eff};
      last_row = ({1'b0, row_ff} + (DIM_W + 1)'(1)) >= {1'b0, height_eff};

      // precision, half-range offset and clamp
      if (req.sample_precision < PREC_MIN) begin
         prec = PREC_MIN;
      end else if (req.sample_precision > PREC_MAX) begin
         prec = PREC_MAX;
      end else begin
         prec = req.sample_precision;
      end
      src_max = ((SAMPLE_W + 1)'(1) << prec) - (SAMPLE_W + 1)'(1);
      offset  = req.sample_signed ? ((RAW_W + 1)'(1) << (prec - PREC_MIN)) : '0;
      shifted = {req.raw_sample[RAW_W-1], req.raw_sample} + offset;
      below   = shifted[RAW_W];
      above   = shifted[RAW_W-1:0] > RAW_W'(src_max);
      if (below) begin
         clamped = '0;
      end else if (above) begin
         clamped = src_max[SAMPLE_W-1:0];
      end else begin
         clamped = shifted[SAMPLE_W-1:0];
      end

      req.ready = !queue_full;
      push      = req.valid && !queue_full;

      push_data.output_wide       = cfg.output_wide;
      push_data.precision         = prec;
      push_data.sample            = clamped;
      push_data.tag.channel_index = chan_ff;
      push_data.tag.pixel_end     = last_ch;
      push_data.tag.tile_end      = last_ch && last_col && last_row;

      // interleave counters
      chan_in = chan_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      if (push) begin
         if (!last_ch) begin
            chan_in = chan_ff + CHAN_W'(1);
         end else begin
            chan_in = '0;
            if (!last_col) begin
               col_in = col_ff + DIM_W'(1);
            end else begin
               col_in = '0;
               row_in = last_row ? '0 : row_ff + DIM_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff <= '0;
         col_ff  <= '0;
         row_ff  <= '0;
      end else begin
         chan_ff <= chan_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
      end
   end

endmodule

// ===== rtl/core/psri_queue.sv =====
`timescale 1ns / 1ps

module psri_queue #(
   parameter int DEPTH = psri_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  psri_pkg::entry_type push_data,
   output logic                full,
   input  logic                pop,
   output psri_pkg::entry_type head,
   output logic                empty
);
   import psri_pkg::*;

   localparam int PTR_W   = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);

   entry_type          slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   always_comb begin
      full  = count_ff == COUNT_W'(DEPTH);
      empty = count_ff == '0;
      head  = slot_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/psri_back.sv =====
`timescale 1ns / 1ps

module psri_back (
   input  logic                clock,
   input  logic                reset,
   input  psri_pkg::entry_type head,
   input  logic                queue_empty,
   output logic                pop,
   psri_rsp_if.source          rsp
);
   import psri_pkg::*;

   back_state_type         state_ff, state_in;
   logic [SAMPLE_W-1:0]    rem_ff, rem_in;
   logic [SAMPLE_W-1:0]    dvd_ff, dvd_in;
   logic [SCALED_W-1:0]    quo_ff, quo_in;
   logic [SAMPLE_W-1:0]    div_ff, div_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   tag_type                tag_ff, tag_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SCALED_W-1:0]    scaled_ff, scaled_in;
   tag_type                out_tag_ff, out_tag_in;

   logic [DIVIDEND_W-1:0]  ext_sample;
   logic [DIVIDEND_W-1:0]  half;
   logic [DIVIDEND_W-1:0]  dividend;
   logic [SAMPLE_W:0]      divisor;
   logic [SAMPLE_W:0]      trial;
   logic [SAMPLE_W:0]      diff;
   logic                   fits;
   logic [SCALED_W-1:0]    quo_next;
   logic                   out_free;
   logic                   load;

   always_comb begin
      // s * outmax + srcmax/2 as shift and subtract
      ext_sample = DIVIDEND_W'(head.sample);
      half       = DIVIDEND_W'((SAMPLE_W'(1) << (head.precision - PREC_MIN)) - SAMPLE_W'(1));
      dividend   = (head.output_wide ? (ext_sample << SCALED_W) : (ext_sample << 8))
                   - ext_sample + half;
      divisor    = ((SAMPLE_W + 1)'(1) << head.precision) - (SAMPLE_W + 1)'(1);

      // one restoring step
      trial    = {rem_ff, dvd_ff[SAMPLE_W-1]};
      diff     = trial - {1'b0, div_ff};
      fits     = trial >= {1'b0, div_ff};
      quo_next = {quo_ff[SCALED_W-2:0], fits};

      out_free = !rsp_valid_ff || rsp.ready;

      state_in     = state_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      quo_in       = quo_ff;
      div_in       = div_ff;
      step_in      = step_ff;
      tag_in       = tag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      scaled_in    = scaled_ff;
      out_tag_in   = out_tag_ff;
      load         = 1'b0;

      case (state_ff)
         BACK_IDLE: begin
            if (!queue_empty) begin
               load     = 1'b1;
               state_in = BACK_RUN;
            end
         end
         BACK_RUN: begin
            if (step_ff != STEP_LAST) begin
               rem_in  = fits ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
               dvd_in  = dvd_ff << 1;
               quo_in  = quo_next;
               step_in = step_ff + STEP_W'(1);
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               scaled_in    = quo_next;
               out_tag_in   = tag_ff;
               if (!queue_empty) begin
                  load = 1'b1;
               end else begin
                  state_in = BACK_IDLE;
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase

      if (load) begin
         rem_in  = dividend[DIVIDEND_W-1:SAMPLE_W];
         dvd_in  = dividend[SAMPLE_W-1:0];
         div_in  = divisor[SAMPLE_W-1:0];
         step_in = '0;
         tag_in  = head.tag;
      end
      pop = load;

      rsp.valid         = rsp_valid_ff;
      rsp.scaled_value  = scaled_ff;
      rsp.channel_index = out_tag_ff.channel_index;
      rsp.pixel_end     = out_tag_ff.pixel_end;
      rsp.tile_end      = out_tag_ff.tile_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      dvd_ff     <= dvd_in;
      quo_ff     <= quo_in;
      div_ff     <= div_in;
      tag_ff     <= tag_in;
      scaled_ff  <= scaled_in;
      out_tag_ff <= out_tag_in;
   end

endmodule

// ===== rtl/core/planar_sample_rescale_interleave_core.sv =====
`timescale 1ns / 1ps

// sample rescaler with interleave tagging
// req_ch carries one decoded component sample per item, with its precision
// and signed flag, in interleaved order: channels of a pixel, pixels along a
// row, rows down the tile
// rsp_ch returns one item per sample: the value rescaled with rounding to 8
// or 16 bits, its channel index and end-of-pixel / end-of-tile marks
// csr_ch writes the registers (output width, channel count, tile size);
// write only while no item is in flight, unknown indexes are dropped
// an accepted req item passes the queue, the divider and the output
// register before rsp valid; the divider in the back end works on one
// item at a time and retires one quotient bit per cycle
// the front end tags items and fills a small queue, so it keeps taking
// items while the divider is busy until the queue is full
// a stalled rsp holds its item in the output register; the divider then
// waits on its last step and the queue backs up into req_ch.ready
// reset (synchronous) restores the register defaults, zeroes the counters
// and empties the queue and the output register
module planar_sample_rescale_interleave_core #(
   parameter int QUEUE_DEPTH = psri_pkg::QUEUE_DEPTH_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   psri_req_if.sink    req_ch,
   psri_rsp_if.source  rsp_ch,
   psri_csr_if.sink    csr_ch
);
   import psri_pkg::*;

   // configuration registers
   cfg_type   cfg_ff, cfg_in;

   // front to queue to back
   logic      push;
   entry_type push_data;
   logic      queue_full;
   logic      pop;
   entry_type head;
   logic      queue_empty;

   // register writes are always taken
   always_comb begin
      csr_ch.ready = 1'b1;
      cfg_in       = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_OUTPUT_WIDE:   cfg_in.output_wide   = csr_ch.data[0];
            CSR_CHANNEL_COUNT: cfg_in.channel_count = csr_ch.data[CCOUNT_W-1:0];
            CSR_TILE_WIDTH:    cfg_in.tile_width    = csr_ch.data[DIM_W-1:0];
            CSR_TILE_HEIGHT:   cfg_in.tile_height   = csr_ch.data[DIM_W-1:0];
            default:           cfg_in               = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.output_wide   <= 1'b0;
         cfg_ff.channel_count <= CCOUNT_W'(1);
         cfg_ff.tile_width    <= DIM_W'(1);
         cfg_ff.tile_height   <= DIM_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: offset, clamp and interleave tags
   psri_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req        (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   // decoupling queue
   psri_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .head      (head),
      .empty     (queue_empty)
   );

   // back: rounding divide by 2^prec - 1 and output register
   psri_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .queue_empty (queue_empty),
      .pop         (pop),
      .rsp         (rsp_ch)
   );

endmodule
